// ===== hdl/rffa_pkg.sv =====
// Shared types and constants of the repulsive force field accumulator.
package rffa_pkg;

  // Internal widths, sized for the widest supported coordinate (48 bits).
  localparam int DELTA_W   = 49;
  localparam int MAG_W     = 49;
  localparam int NET_W     = 49;
  localparam int ACC_W     = 48;
  localparam int PMAG_W    = 31;
  localparam int CFG_W     = 31;
  localparam int RAD_W     = 64;
  localparam int ROOT_W    = 32;
  localparam int QUO_W     = 33;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SAFE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHELL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd4;

  // Squared distance of 0.001 m in Q32.32.
  localparam logic [RAD_W-1:0] EPS_SQ = 64'd4295;

  typedef struct packed {
    logic [CFG_W-1:0] safe_radius;
    logic [CFG_W-1:0] shell_radius;
    logic [CFG_W-1:0] gain;
    logic [CFG_W-1:0] force_limit;
    logic             mode;
  } cfg_t;

  // One classified point as it travels from the front to the back.
  typedef struct packed {
    logic                    near;
    logic                    last;
    logic [2:0][PMAG_W-1:0]  pmag;
    logic [2:0]              psign;
    logic [2:0][DELTA_W-1:0] gdelta;
  } entry_t;

  typedef struct packed {
    logic             start;
    logic [RAD_W-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_rsp_t;

  typedef struct packed {
    logic              start;
    logic [RAD_W-1:0]  dividend;
    logic [ROOT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== hdl/rffa_front.sv =====
// Front end: forms the point and goal offsets and classifies each point.
module rffa_front import rffa_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  input  logic signed [COORD_WIDTH-1:0] point_z_i,
  input  logic signed [COORD_WIDTH-1:0] agent_x_i,
  input  logic signed [COORD_WIDTH-1:0] agent_y_i,
  input  logic signed [COORD_WIDTH-1:0] agent_z_i,
  input  logic signed [COORD_WIDTH-1:0] goal_x_i,
  input  logic signed [COORD_WIDTH-1:0] goal_y_i,
  input  logic signed [COORD_WIDTH-1:0] goal_z_i,
  input  logic                          last_point_i,
  output entry_t                        entry_o
);

  logic signed [DELTA_W-1:0] pv [3];
  logic signed [DELTA_W-1:0] av [3];
  logic signed [DELTA_W-1:0] gv [3];
  logic signed [DELTA_W-1:0] dv [3];
  logic        [MAG_W-1:0]   mag [3];
  logic        [2:0]         far;
  logic        [2:0]         zero;

  // Sign-extend all coordinates to the common offset width.
  assign pv[0] = DELTA_W'(point_x_i);
  assign pv[1] = DELTA_W'(point_y_i);
  assign pv[2] = DELTA_W'(point_z_i);
  assign av[0] = DELTA_W'(agent_x_i);
  assign av[1] = DELTA_W'(agent_y_i);
  assign av[2] = DELTA_W'(agent_z_i);
  assign gv[0] = DELTA_W'(goal_x_i);
  assign gv[1] = DELTA_W'(goal_y_i);
  assign gv[2] = DELTA_W'(goal_z_i);

  // Per axis: exact offsets, magnitudes and the far and zero tests.
  for (genvar i = 0; i < 3; i++) begin : g_axis
    assign dv[i]   = pv[i] - av[i];
    assign mag[i]  = dv[i][DELTA_W-1] ? MAG_W'(-dv[i]) : MAG_W'(dv[i]);
    assign far[i]  = |mag[i][MAG_W-1:PMAG_W];
    assign zero[i] = (mag[i] == '0);
    assign entry_o.pmag[i]   = mag[i][PMAG_W-1:0];
    assign entry_o.psign[i]  = dv[i][DELTA_W-1];
    assign entry_o.gdelta[i] = gv[i] - av[i];
  end

  // A point is worth the back end's time only if it is neither far nor on the agent.
  assign entry_o.near = ~(|far) & ~(&zero);
  assign entry_o.last = last_point_i;

endmodule

// ===== hdl/rffa_queue.sv =====
// Two-entry queue that decouples the front end from the back end.
module rffa_queue import rffa_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t wdata_i,
  output logic   full_o,
  input  logic   pop_i,
  output entry_t rdata_o,
  output logic   empty_o
);

  entry_t     slots_q [2];
  logic       wptr_q;
  logic       rptr_q;
  logic [1:0] count_q;
  logic       do_push;
  logic       do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign rdata_o = slots_q[rptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop) rptr_q <= ~rptr_q;
      if (do_push && !do_pop) count_q <= count_q + 2'd1;
      else if (!do_push && do_pop) count_q <= count_q - 2'd1;
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_push) slots_q[wptr_q] <= wdata_i;
  end

endmodule

// ===== hdl/rffa_sqrt.sv =====
// Iterative integer square root, one result bit per cycle.
module rffa_sqrt import rffa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sqrt_req_t req_i,
  output sqrt_rsp_t rsp_o
);

  logic             run_q;
  logic             done_q;
  logic [4:0]       cnt_q;
  logic [RAD_W-1:0] n_q;
  logic [RAD_W-1:0] r_q;
  logic [RAD_W-1:0] b_q;
  logic [RAD_W-1:0] rb;
  logic             fits;

  assign rb   = r_q + b_q;
  assign fits = (n_q >= rb);

  // Control: 32 iterations after each start.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: restoring digit-by-digit root.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      n_q <= req_i.radicand;
      r_q <= '0;
      b_q <= {2'b01, {(RAD_W-2){1'b0}}};
    end else if (run_q) begin
      if (fits) begin
        n_q <= n_q - rb;
        r_q <= (r_q >> 1) + b_q;
      end else begin
        r_q <= r_q >> 1;
      end
      b_q <= b_q >> 2;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.root = r_q[ROOT_W-1:0];

endmodule

// ===== hdl/rffa_div.sv =====
// Iterative restoring divider for 33-bit quotients, one bit per cycle.
module rffa_div import rffa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              run_q;
  logic              done_q;
  logic [5:0]        cnt_q;
  logic [ROOT_W-1:0] rem_q;
  logic [QUO_W-1:0]  dq_q;
  logic [QUO_W-1:0]  quo_q;
  logic [ROOT_W-1:0] dvs_q;
  logic [QUO_W-1:0]  trial;
  logic [QUO_W-1:0]  diff;
  logic              fits;

  // The caller guarantees the quotient fits, so the top bits start below the divisor.
  assign trial = {rem_q, dq_q[QUO_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = (trial >= {1'b0, dvs_q});

  // Control: 33 iterations after each start.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(QUO_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= {1'b0, req_i.dividend[RAD_W-1:QUO_W]};
      dq_q  <= req_i.dividend[QUO_W-1:0];
      dvs_q <= req_i.divisor;
    end else if (run_q) begin
      rem_q <= fits ? diff[ROOT_W-1:0] : trial[ROOT_W-1:0];
      dq_q  <= dq_q << 1;
      quo_q <= {quo_q[QUO_W-2:0], fits};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== hdl/rffa_back.sv =====
// Back end: sequences the force math on the shared multiplier, root and divider.
module rffa_back import rffa_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cfg_t                          cfg_i,
  input  logic                          q_empty_i,
  input  entry_t                        q_data_i,
  output logic                          q_pop_o,
  output sqrt_req_t                     sqrt_req_o,
  input  sqrt_rsp_t                     sqrt_rsp_i,
  output div_req_t                      div_req_o,
  input  div_rsp_t                      div_rsp_i,
  input  logic                          pop_i,
  output logic                          out_valid_o,
  output logic signed [COORD_WIDTH-1:0] force_x_o,
  output logic signed [COORD_WIDTH-1:0] force_y_o,
  output logic signed [COORD_WIDTH-1:0] force_z_o
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_SQ, ST_SQ_END, ST_CAP_LIM, ST_CAP_TEST, ST_SQRT_GO, ST_SQRT_WAIT,
    ST_P_CHECK, ST_INVD_GO, ST_INVD_WAIT, ST_INVS_GO, ST_INVS_WAIT, ST_FMUL,
    ST_FMIN, ST_CMUL, ST_CDIV_GO, ST_CDIV_WAIT, ST_CHECK_LAST, ST_RED,
    ST_CAP_SETUP, ST_EMIT
  } state_e;

  typedef enum logic [1:0] {PH_POINT, PH_GOAL, PH_CAP} phase_e;

  localparam logic signed [NET_W-1:0] OUT_HI =
    NET_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [NET_W-1:0] OUT_LO = -OUT_HI - NET_W'(1);
  localparam logic signed [NET_W-1:0] ACC_HI =
    NET_W'((64'sd1 <<< (ACC_W - 1)) - 64'sd1);
  localparam logic signed [NET_W-1:0] ACC_LO = -ACC_HI - NET_W'(1);

  state_e                          state_q;
  phase_e                          phase_q;
  logic        [1:0]               idx_q;
  logic        [MAG_W-1:0]         mag_q [3];
  logic        [2:0]               sign_q;
  logic signed [ACC_W-1:0]         sum_q [3];
  logic signed [NET_W-1:0]         net_q [3];
  logic        [RAD_W-1:0]         s_q;
  logic        [ROOT_W-1:0]        d_q;
  logic        [QUO_W-1:0]         inv_q;
  logic        [RAD_W-1:0]         prod_q;
  logic        [CFG_W-1:0]         factor_q;
  logic                            last_q;
  logic        [2:0][DELTA_W-1:0]  gdelta_q;
  logic                            shifted_q;
  logic                            out_valid_q;
  logic signed [COORD_WIDTH-1:0]   force_q [3];

  logic        [CFG_W-1:0]         ge_eff;
  logic        [CFG_W-1:0]         le_eff;
  logic        [CFG_W-1:0]         gm;
  logic        [ROOT_W-1:0]        s2;
  logic        [QUO_W-1:0]         mul_a;
  logic        [CFG_W-1:0]         mul_b;
  logic        [RAD_W-1:0]         mul_p;
  logic        [ACC_W-1:0]         f_wide;
  logic        [MAG_W-1:0]         mag_or;
  logic signed [NET_W-1:0]         qs;
  logic signed [NET_W-1:0]         sum_ext;
  logic signed [NET_W-1:0]         sum_new;
  logic signed [ACC_W-1:0]         sum_sat;
  logic signed [NET_W-1:0]         gd_sel [3];
  logic signed [COORD_WIDTH-1:0]   clamp [3];

  // Effective gain and limit; mode 1 halves both.
  assign ge_eff = cfg_i.mode ? (cfg_i.gain >> 1) : cfg_i.gain;
  assign le_eff = cfg_i.mode ? (cfg_i.force_limit >> 1) : cfg_i.force_limit;
  assign gm     = (ge_eff < le_eff) ? ge_eff : le_eff;
  assign s2     = {cfg_i.safe_radius, 1'b0};

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_SQ: begin
        mul_a = QUO_W'(mag_q[idx_q][PMAG_W-1:0]);
        mul_b = mag_q[idx_q][PMAG_W-1:0];
      end
      ST_FMUL: begin
        mul_a = inv_q;
        mul_b = ge_eff;
      end
      ST_CMUL: begin
        mul_a = QUO_W'(factor_q);
        mul_b = mag_q[idx_q][PMAG_W-1:0];
      end
      ST_CAP_LIM: begin
        mul_a = QUO_W'(cfg_i.force_limit);
        mul_b = cfg_i.force_limit;
      end
      default: ;
    endcase
  end
  assign mul_p = RAD_W'(mul_a) * RAD_W'(mul_b);

  // Repulsion magnitude before the limit.
  assign f_wide = prod_q[RAD_W-1:RAD_W-ACC_W];

  assign mag_or = mag_q[0] | mag_q[1] | mag_q[2];

  // Quotient as a signed term and the saturating accumulator update.
  assign qs      = NET_W'(div_rsp_i.quotient);
  assign sum_ext = NET_W'(sum_q[idx_q]);
  assign sum_new = sign_q[idx_q] ? (sum_ext + qs) : (sum_ext - qs);
  always_comb begin
    if (sum_new > ACC_HI) sum_sat = ACC_HI[ACC_W-1:0];
    else if (sum_new < ACC_LO) sum_sat = ACC_LO[ACC_W-1:0];
    else sum_sat = sum_new[ACC_W-1:0];
  end

  // Output clamp and goal offsets per axis.
  for (genvar i = 0; i < 3; i++) begin : g_axis
    assign gd_sel[i] = $signed(gdelta_q[i]);
    always_comb begin
      if (net_q[i] > OUT_HI) clamp[i] = OUT_HI[COORD_WIDTH-1:0];
      else if (net_q[i] < OUT_LO) clamp[i] = OUT_LO[COORD_WIDTH-1:0];
      else clamp[i] = net_q[i][COORD_WIDTH-1:0];
    end
  end

  // Requests to the shared units.
  always_comb begin
    sqrt_req_o.start    = (state_q == ST_SQRT_GO);
    sqrt_req_o.radicand = s_q;
    div_req_o.start     = 1'b0;
    div_req_o.dividend  = RAD_W'(1) << 32;
    div_req_o.divisor   = d_q;
    case (state_q)
      ST_INVD_GO: div_req_o.start = 1'b1;
      ST_INVS_GO: begin
        div_req_o.start   = 1'b1;
        div_req_o.divisor = s2;
      end
      ST_CDIV_GO: begin
        div_req_o.start    = 1'b1;
        div_req_o.dividend = prod_q;
      end
      default: ;
    endcase
  end

  assign q_pop_o     = (state_q == ST_IDLE) & ~q_empty_i;
  assign out_valid_o = out_valid_q;
  assign force_x_o   = force_q[0];
  assign force_y_o   = force_q[1];
  assign force_z_o   = force_q[2];

  // Sequencer with its datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_POINT;
      idx_q       <= '0;
      shifted_q   <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) sum_q[i] <= '0;
    end else begin
      if (pop_i && out_valid_q) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (!q_empty_i) begin
            for (int i = 0; i < 3; i++) mag_q[i] <= MAG_W'(q_data_i.pmag[i]);
            sign_q   <= q_data_i.psign;
            last_q   <= q_data_i.last;
            gdelta_q <= q_data_i.gdelta;
            phase_q  <= PH_POINT;
            s_q      <= '0;
            idx_q    <= '0;
            state_q  <= q_data_i.near ? ST_SQ : ST_CHECK_LAST;
          end
        end
        ST_SQ: begin
          s_q <= s_q + mul_p;
          if (idx_q == 2'd2) state_q <= ST_SQ_END;
          else idx_q <= idx_q + 2'd1;
        end
        ST_SQ_END: begin
          case (phase_q)
            PH_POINT: state_q <= ST_SQRT_GO;
            PH_GOAL: begin
              if (shifted_q || s_q >= EPS_SQ) state_q <= ST_SQRT_GO;
              else state_q <= ST_CAP_SETUP;
            end
            default: state_q <= ST_CAP_LIM;
          endcase
        end
        ST_CAP_LIM: begin
          prod_q  <= mul_p;
          state_q <= ST_CAP_TEST;
        end
        ST_CAP_TEST: begin
          if (shifted_q || (s_q > prod_q && s_q >= EPS_SQ)) state_q <= ST_SQRT_GO;
          else state_q <= ST_EMIT;
        end
        ST_SQRT_GO: state_q <= ST_SQRT_WAIT;
        ST_SQRT_WAIT: begin
          if (sqrt_rsp_i.done) begin
            d_q   <= sqrt_rsp_i.root;
            idx_q <= '0;
            case (phase_q)
              PH_POINT: state_q <= ST_P_CHECK;
              PH_GOAL: begin
                factor_q <= gm;
                state_q  <= ST_CMUL;
              end
              default: begin
                factor_q <= cfg_i.force_limit;
                state_q  <= ST_CMUL;
              end
            endcase
          end
        end
        ST_P_CHECK: begin
          if (d_q < ROOT_W'(cfg_i.shell_radius) && d_q < s2) state_q <= ST_INVD_GO;
          else state_q <= ST_CHECK_LAST;
        end
        ST_INVD_GO: state_q <= ST_INVD_WAIT;
        ST_INVD_WAIT: begin
          if (div_rsp_i.done) begin
            inv_q   <= div_rsp_i.quotient;
            state_q <= ST_INVS_GO;
          end
        end
        ST_INVS_GO: state_q <= ST_INVS_WAIT;
        ST_INVS_WAIT: begin
          if (div_rsp_i.done) begin
            inv_q   <= inv_q - div_rsp_i.quotient;
            state_q <= ST_FMUL;
          end
        end
        ST_FMUL: begin
          prod_q  <= mul_p;
          state_q <= ST_FMIN;
        end
        ST_FMIN: begin
          factor_q <= (f_wide > ACC_W'(le_eff)) ? le_eff : f_wide[CFG_W-1:0];
          idx_q    <= '0;
          state_q  <= ST_CMUL;
        end
        ST_CMUL: begin
          prod_q  <= mul_p;
          state_q <= ST_CDIV_GO;
        end
        ST_CDIV_GO: state_q <= ST_CDIV_WAIT;
        ST_CDIV_WAIT: begin
          if (div_rsp_i.done) begin
            // Apply one component: repulsion, goal pull or capped value.
            case (phase_q)
              PH_POINT: sum_q[idx_q] <= sum_sat;
              PH_GOAL: begin
                net_q[idx_q] <= sign_q[idx_q] ? (net_q[idx_q] - qs) : (net_q[idx_q] + qs);
              end
              default: net_q[idx_q] <= sign_q[idx_q] ? -qs : qs;
            endcase
            if (idx_q == 2'd2) begin
              case (phase_q)
                PH_POINT: state_q <= ST_CHECK_LAST;
                PH_GOAL: state_q <= ST_CAP_SETUP;
                default: state_q <= ST_EMIT;
              endcase
            end else begin
              idx_q   <= idx_q + 2'd1;
              state_q <= ST_CMUL;
            end
          end
        end
        ST_CHECK_LAST: begin
          if (!last_q) begin
            state_q <= ST_IDLE;
          end else begin
            for (int i = 0; i < 3; i++) begin
              net_q[i]  <= NET_W'(sum_q[i]);
              sum_q[i]  <= '0;
              mag_q[i]  <= gd_sel[i][NET_W-1] ? MAG_W'(-gd_sel[i]) : MAG_W'(gd_sel[i]);
              sign_q[i] <= gd_sel[i][NET_W-1];
            end
            shifted_q <= 1'b0;
            phase_q   <= PH_GOAL;
            state_q   <= cfg_i.mode ? ST_RED : ST_EMIT;
          end
        end
        ST_RED: begin
          // Shift all three magnitudes until they fit in 31 bits.
          if (|mag_or[MAG_W-1:PMAG_W]) begin
            for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
            shifted_q <= 1'b1;
          end else begin
            s_q     <= '0;
            idx_q   <= '0;
            state_q <= ST_SQ;
          end
        end
        ST_CAP_SETUP: begin
          for (int i = 0; i < 3; i++) begin
            mag_q[i]  <= net_q[i][NET_W-1] ? MAG_W'(-net_q[i]) : MAG_W'(net_q[i]);
            sign_q[i] <= net_q[i][NET_W-1];
          end
          shifted_q <= 1'b0;
          phase_q   <= PH_CAP;
          state_q   <= ST_RED;
        end
        ST_EMIT: begin
          if (!out_valid_q) begin
            for (int i = 0; i < 3; i++) force_q[i] <= clamp[i];
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // The root unit only finishes while the sequencer waits for it.
  a_sqrt_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_rsp_i.done |-> state_q == ST_SQRT_WAIT)
    else $error("square root finished outside its wait state");

  // The divider only finishes while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp_i.done |-> (state_q == ST_INVD_WAIT || state_q == ST_INVS_WAIT ||
                        state_q == ST_CDIV_WAIT))
    else $error("divider finished outside a wait state");

  // A free output register is loaded on the cycle after emit.
  a_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && !out_valid_q) |=> out_valid_q)
    else $error("emitted result was not registered");

endmodule

// ===== hdl/repulsive_force_field_accumulator.sv =====
// Top level of the repulsive force field accumulator: registers, queue, units and back end.
// A far point or one on the agent skips the force math in the back end; any other point
// takes a square root, and one inside the radii also five divisions, on the shared
// one-bit-per-cycle root and divider. A last point in mode 1 adds the goal pull and the cap.
// The result is registered once the output is free; a two-entry queue decouples the input.
// Reset is asynchronous and active low; it restores the register defaults and clears the sums.
module repulsive_force_field_accumulator import rffa_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DAT_W-1:0]          cfg_data_i,
  input  logic                          push,
  output logic                          full,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  input  logic signed [COORD_WIDTH-1:0] point_z_i,
  input  logic signed [COORD_WIDTH-1:0] agent_x_i,
  input  logic signed [COORD_WIDTH-1:0] agent_y_i,
  input  logic signed [COORD_WIDTH-1:0] agent_z_i,
  input  logic signed [COORD_WIDTH-1:0] goal_x_i,
  input  logic signed [COORD_WIDTH-1:0] goal_y_i,
  input  logic signed [COORD_WIDTH-1:0] goal_z_i,
  input  logic                          last_point_i,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [COORD_WIDTH-1:0] force_x_o,
  output logic signed [COORD_WIDTH-1:0] force_y_o,
  output logic signed [COORD_WIDTH-1:0] force_z_o
);

  cfg_t      cfg_q;
  entry_t    front_entry;
  entry_t    q_data;
  logic      q_empty;
  logic      q_pop;
  logic      out_valid;
  sqrt_req_t sqrt_req;
  sqrt_rsp_t sqrt_rsp;
  div_req_t  div_req;
  div_rsp_t  div_rsp;

  assign cfg_ready_o = 1'b1;
  assign empty       = ~out_valid;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.safe_radius  <= CFG_W'(6554);
      cfg_q.shell_radius <= CFG_W'(131072);
      cfg_q.gain         <= CFG_W'(65536);
      cfg_q.force_limit  <= CFG_W'(65536);
      cfg_q.mode         <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_SAFE:  cfg_q.safe_radius  <= cfg_data_i[CFG_W-1:0];
        REG_SHELL: cfg_q.shell_radius <= cfg_data_i[CFG_W-1:0];
        REG_GAIN:  cfg_q.gain         <= cfg_data_i[CFG_W-1:0];
        REG_LIMIT: cfg_q.force_limit  <= cfg_data_i[CFG_W-1:0];
        REG_MODE:  cfg_q.mode         <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  rffa_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .point_z_i    (point_z_i),
    .agent_x_i    (agent_x_i),
    .agent_y_i    (agent_y_i),
    .agent_z_i    (agent_z_i),
    .goal_x_i     (goal_x_i),
    .goal_y_i     (goal_y_i),
    .goal_z_i     (goal_z_i),
    .last_point_i (last_point_i),
    .entry_o      (front_entry)
  );

  rffa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_entry),
    .full_o  (full),
    .pop_i   (q_pop),
    .rdata_o (q_data),
    .empty_o (q_empty)
  );

  rffa_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sqrt_req),
    .rsp_o  (sqrt_rsp)
  );

  rffa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  rffa_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_empty_i   (q_empty),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .sqrt_req_o  (sqrt_req),
    .sqrt_rsp_i  (sqrt_rsp),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .pop_i       (pop),
    .out_valid_o (out_valid),
    .force_x_o   (force_x_o),
    .force_y_o   (force_y_o),
    .force_z_o   (force_z_o)
  );

endmodule

// ===== dv/repulsive_force_field_accumulator_test.sv =====
// Self-checking testbench of the repulsive force field accumulator with its own force predictor.
`timescale 1ns / 1ps

module repulsive_force_field_accumulator_test import rffa_pkg::*;;

  typedef struct {
    logic signed [31:0] px, py, pz;
    logic signed [31:0] ax, ay, az;
    logic signed [31:0] gx, gy, gz;
    logic               last;
  } point_req_t;

  typedef struct {
    logic signed [31:0] fx, fy, fz;
  } force_t;

  localparam longint unsigned MAG_CAP = 64'd1 << 31;
  localparam longint unsigned EPS_LIM = 64'd4295;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = REG_SAFE;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;
  logic push = 1'b0;
  logic full;
  logic signed [31:0] point_x_i = '0, point_y_i = '0, point_z_i = '0;
  logic signed [31:0] agent_x_i = '0, agent_y_i = '0, agent_z_i = '0;
  logic signed [31:0] goal_x_i = '0, goal_y_i = '0, goal_z_i = '0;
  logic last_point_i = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic signed [31:0] force_x_o, force_y_o, force_z_o;

  repulsive_force_field_accumulator #(.COORD_WIDTH(32)) i_dut (.*);

  // Predictor state: register copies and the three force sums.
  longint unsigned safe_r = 6554, shell_r = 131072, gain_r = 65536, limit_r = 65536;
  bit mode_r = 1'b0;
  longint sum_f[3] = '{0, 0, 0};

  point_req_t point_queue[$];
  force_t     force_queue[$];
  point_req_t held;
  int  send_gap = 0, pop_gap = 0, hold_cnt = 0, err_count = 0;
  bit  no_idle = 1'b0, hold_req = 1'b0, hold_done = 1'b0;

  // Clock.
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog.
  initial begin
    #100_000_000;
    $display("repulsive_force_field_accumulator test failed");
    $finish;
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint clamp(longint v, int w);
    longint hi, lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint unsigned abs_of(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic longint with_sign(longint ref_v, longint unsigned c);
    return ref_v < 0 ? -longint'(c) : longint'(c);
  endfunction

  // Shifts the three magnitudes below 2^31 and returns the shift.
  function automatic int shrink(ref longint unsigned m[3]);
    int sh;
    sh = 0;
    while (((m[0] | m[1] | m[2]) >> sh) >= MAG_CAP) sh++;
    for (int i = 0; i < 3; i++) m[i] >>= sh;
    return sh;
  endfunction

  // Adds one point's repulsion and, on the last point, queues the expected force.
  function automatic void accumulate_point(point_req_t r);
    longint pv[3], av[3], gv[3], dv[3], net[3];
    longint unsigned m[3], ge, le, s, d, inv_d, inv_s, f, gm;
    int sh;
    force_t res;
    pv = '{r.px, r.py, r.pz};
    av = '{r.ax, r.ay, r.az};
    gv = '{r.gx, r.gy, r.gz};
    ge = mode_r ? gain_r >> 1 : gain_r;
    le = mode_r ? limit_r >> 1 : limit_r;
    for (int i = 0; i < 3; i++) begin
      dv[i] = pv[i] - av[i];
      m[i] = abs_of(dv[i]);
    end
    // Repulsion from a point inside both radii.
    if ((m[0] | m[1] | m[2]) < MAG_CAP) begin
      s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      if (s != 0) begin
        d = int_sqrt(s);
        if (d < shell_r && d < 2 * safe_r) begin
          inv_d = (64'd1 << 32) / d;
          inv_s = (64'd1 << 32) / (2 * safe_r);
          f = (ge * (inv_d - inv_s)) >> 16;
          if (f > le) f = le;
          for (int i = 0; i < 3; i++)
            sum_f[i] = clamp(sum_f[i] - with_sign(dv[i], f * m[i] / d), 48);
        end
      end
    end
    if (!r.last) return;
    net = sum_f;
    if (mode_r) begin
      // Unit pull toward the goal, skipped when the goal is reached.
      gm = ge < le ? ge : le;
      for (int i = 0; i < 3; i++) begin
        dv[i] = gv[i] - av[i];
        m[i] = abs_of(dv[i]);
      end
      sh = shrink(m);
      s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      if (sh > 0 || s >= EPS_LIM) begin
        d = int_sqrt(s);
        for (int i = 0; i < 3; i++) net[i] += with_sign(dv[i], gm * m[i] / d);
      end
      // Magnitude cap at the full limit.
      for (int i = 0; i < 3; i++) m[i] = abs_of(net[i]);
      sh = shrink(m);
      s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      if (sh > 0 || (s > limit_r * limit_r && s >= EPS_LIM)) begin
        d = int_sqrt(s);
        for (int i = 0; i < 3; i++) net[i] = with_sign(net[i], limit_r * m[i] / d);
      end
    end
    res.fx = 32'(clamp(net[0], 32));
    res.fy = 32'(clamp(net[1], 32));
    res.fz = 32'(clamp(net[2], 32));
    force_queue.push_back(res);
    sum_f = '{0, 0, 0};
  endfunction

  // Point driver: a request is accepted when push is high and full is low.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) accumulate_point(held);
      if (push && full) begin
        // Hold the request until it is taken.
      end else if (send_gap > 0) begin
        send_gap--;
        push <= 1'b0;
      end else if (point_queue.size() > 0) begin
        held = point_queue.pop_front();
        point_x_i <= held.px; point_y_i <= held.py; point_z_i <= held.pz;
        agent_x_i <= held.ax; agent_y_i <= held.ay; agent_z_i <= held.az;
        goal_x_i <= held.gx; goal_y_i <= held.gy; goal_z_i <= held.gz;
        last_point_i <= held.last;
        push <= 1'b1;
        send_gap = no_idle ? 0 : $urandom_range(0, 16);
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Force monitor: compares each popped result with the oldest expectation.
  always @(posedge clk_i) begin
    force_t e;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (force_queue.size() == 0) begin
          $error("unexpected force result %0d %0d %0d", force_x_o, force_y_o, force_z_o);
          err_count++;
        end else begin
          e = force_queue.pop_front();
          if (force_x_o !== e.fx) begin
            $error("force_x expected %0d actual %0d", e.fx, force_x_o);
            err_count++;
          end
          if (force_y_o !== e.fy) begin
            $error("force_y expected %0d actual %0d", e.fy, force_y_o);
            err_count++;
          end
          if (force_z_o !== e.fz) begin
            $error("force_z expected %0d actual %0d", e.fz, force_z_o);
            err_count++;
          end
        end
        pop_gap = no_idle ? 0 : $urandom_range(0, 16);
      end
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_cnt = 4000;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        pop <= 1'b0;
      end else if (pop_gap > 0) begin
        pop_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // One register write over the configuration channel.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint unsigned val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= {1'($urandom_range(0, 1)), val[30:0]};
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_SAFE:  safe_r  = val & 64'h7fff_ffff;
      REG_SHELL: shell_r = val & 64'h7fff_ffff;
      REG_GAIN:  gain_r  = val & 64'h7fff_ffff;
      REG_LIMIT: limit_r = val & 64'h7fff_ffff;
      REG_MODE:  mode_r  = val[0];
      default: ;
    endcase
  endtask

  task automatic write_all(longint unsigned sf, longint unsigned sh, longint unsigned g,
                           longint unsigned l, bit md);
    write_reg(REG_SAFE, sf);
    write_reg(REG_SHELL, sh);
    write_reg(REG_GAIN, g);
    write_reg(REG_LIMIT, l);
    write_reg(REG_MODE, md);
  endtask

  // Waits until every request is taken and every force has been checked.
  task automatic drain();
    do @(posedge clk_i);
    while (point_queue.size() != 0 || push || force_queue.size() != 0);
    repeat (1000) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] sat32(longint v);
    return 32'(clamp(v, 32));
  endfunction

  function automatic longint spread(longint unsigned h);
    if (h > 64'h3fff_ffff) h = 64'h3fff_ffff;
    return longint'($urandom_range(0, 32'(2 * h))) - longint'(h);
  endfunction

  function automatic void add_point(longint ax, longint ay, longint az, longint px,
                                    longint py, longint pz, longint gx, longint gy,
                                    longint gz, bit last);
    point_req_t r;
    r.ax = sat32(ax); r.ay = sat32(ay); r.az = sat32(az);
    r.px = sat32(px); r.py = sat32(py); r.pz = sat32(pz);
    r.gx = sat32(gx); r.gy = sat32(gy); r.gz = sat32(gz);
    r.last = last;
    point_queue.push_back(r);
  endfunction

  // One cloud around a random agent; most points fall inside the radii unless single_far.
  function automatic int queue_cloud(int n, bit single_far);
    longint av[3], gv[3], pv[3];
    longint unsigned reach;
    int kind;
    reach = shell_r < 2 * safe_r ? shell_r : 2 * safe_r;
    if (reach > 64'h7fff_ffff) reach = 64'h7fff_ffff;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      if (kind < 5) av[i] = spread(64'h10_0000);
      else if (kind < 8) av[i] = int'($urandom);
      else av[i] = $urandom_range(0, 1) ? 64'sh7fff_ffff : -64'sh8000_0000;
    end
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      if (kind < 3) gv[i] = av[i];
      else if (kind < 5) gv[i] = av[i] + spread(30);
      else gv[i] = int'($urandom);
    end
    for (int k = 0; k < n; k++) begin
      kind = single_far ? 1 : $urandom_range(0, 9);
      for (int i = 0; i < 3; i++) begin
        if (kind == 0) pv[i] = av[i];
        else if (kind < 3) pv[i] = int'($urandom);
        else pv[i] = av[i] + spread(reach / 2);
      end
      add_point(av[0], av[1], av[2], pv[0], pv[1], pv[2], gv[0], gv[1], gv[2], k == n - 1);
    end
    return n;
  endfunction

  function automatic longint unsigned pick_reg();
    int c;
    c = $urandom_range(0, 9);
    if (c == 0) return 0;
    if (c == 1) return 64'h7fff_ffff;
    if (c < 5) return $urandom_range(1, 32'h7fff_ffff);
    return $urandom_range(1000, 300000);
  endfunction

  // Stimulus: directed points first, then random clouds under several settings.
  initial begin
    int sent;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Register defaults: zero distance, a near point, a far point and extreme coordinates.
    add_point(0, 0, 0, 0, 0, 0, 0, 0, 0, 1);
    add_point(0, 0, 0, 3000, 0, 0, 0, 0, 0, 1);
    add_point(100, -200, 300, -1900, 1800, -1700, 0, 0, 0, 0);
    add_point(100, -200, 300, 100, -200, 300, 0, 0, 0, 0);
    add_point(100, -200, 300, 100, 13107, 300, 0, 0, 0, 1);
    add_point(-64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000, 64'sh7fff_ffff,
              64'sh7fff_ffff, 64'sh7fff_ffff, 0, 0, 0, 1);
    add_point(64'sh7fff_ffff, 0, 0, 64'sh7fff_fff0, 5, -5, 0, 0, 0, 1);
    add_point(-64'sh8000_0000, 0, 0, -64'sh7fff_fff0, 0, 0, 0, 0, 0, 0);
    add_point(0, 0, 0, 1, 1, 1, 0, 0, 0, 1);
    drain();

    // Goal pull and cap: goal on the agent, goal just inside and outside the tolerance, far goal.
    write_reg(REG_MODE, 1);
    add_point(0, 0, 0, 500, 0, 0, 0, 0, 0, 1);
    add_point(0, 0, 0, 0, 0, 0, 40, 0, 0, 1);
    add_point(0, 0, 0, 0, 0, 0, 66, 0, 0, 1);
    add_point(-64'sh8000_0000, -64'sh8000_0000, 0, 0, 0, 0, 64'sh7fff_ffff,
              64'sh7fff_ffff, 64'sh7fff_ffff, 1);
    add_point(1000, 1000, 1000, 1200, 1000, 1000, -64'sh8000_0000, 0, 0, 1);
    drain();

    // Largest gain and limit: two strong pushes overflow the outputs.
    write_all(64'h7fff_ffff, 64'h7fff_ffff, 64'h7fff_ffff, 64'h7fff_ffff, 0);
    add_point(0, 0, 0, 1, 0, 0, 0, 0, 0, 0);
    add_point(0, 0, 0, 1, 0, 0, 0, 0, 0, 1);
    add_point(0, 0, 0, 0, -2, 0, 0, 0, 0, 0);
    add_point(0, 0, 0, 0, -1, 0, 0, 0, 0, 1);
    add_point(0, 0, 0, 0, 0, 0, 5, 5, 5, 1);
    drain();
    write_reg(REG_MODE, 1);
    add_point(0, 0, 0, 1, 1, 0, 64'sh7fff_ffff, 0, 0, 1);
    drain();

    // Random phases; the first keeps the output side stalled while short clouds flow in.
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 0) write_all(6554, 131072, 65536, 65536, 0);
      else if (ph == 1) write_all(0, 0, 0, 0, 1);
      else if (ph == 2) write_all(64'h7fff_ffff, 64'h7fff_ffff, 64'h7fff_ffff, 1000, 1);
      else write_all(pick_reg(), pick_reg(), pick_reg(), pick_reg(), $urandom_range(0, 1));
      no_idle = (ph == 0 || ph == 4);
      if (ph == 0) hold_req = 1'b1;
      sent = 0;
      while (sent < 205) begin
        if (ph == 0 && sent < 40) sent += queue_cloud(1, 1'b1);
        else sent += queue_cloud($urandom_range(1, 8), 1'b0);
      end
      drain();
    end

    if (err_count == 0) begin
      $display("repulsive_force_field_accumulator test passed");
    end else begin
      $display("repulsive_force_field_accumulator test failed");
    end
    $finish;
  end

endmodule
